### src/cfs_pkg.sv
// ============================================================================
// cfs_pkg
// Shared types, widths and helpers of the Cholesky factor-and-solve block.
// ============================================================================
package cfs_pkg;

    localparam int ORD    = 16;                 // largest matrix order
    localparam int IDX_W  = 4;                  // row / column index width
    localparam int ADDR_W = 2 * IDX_W;          // matrix store address width
    localparam int SIZE_W = 5;                  // order register width
    localparam int DATA_W = 32;                 // Q16.16 word
    localparam int FRAC   = 16;                 // fraction bits
    localparam int ACC_W  = 52;                 // dot-product accumulator width
    localparam int DIV_W  = DATA_W + FRAC;      // dividend / radicand width
    localparam int SQ_STEPS = DIV_W / 2;        // two radicand bits per step
    localparam int CNT_W  = 6;                  // holds DIV_W

    typedef enum logic [1:0] {
        OP_LOAD_MAT = 2'd0,
        OP_FACTOR   = 2'd1,
        OP_LOAD_RHS = 2'd2,
        OP_SOLVE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_PD    = 2'd1,
        ST_NO_FACTOR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_ENTRY, S_MAC, S_W1, S_W2, S_CALC, S_RUN, S_EMIT_RD, S_EMIT, S_STATUS
    } t_state;

    typedef enum logic [1:0] {
        PH_FACT, PH_FWD, PH_BWD
    } t_phase;

    typedef enum logic [1:0] {
        BASE_MAT, BASE_RHS, BASE_WORK
    } t_base;

    typedef struct packed {
        logic              acc_clr;
        logic              mac_issue;
        logic              fa_rd;
        logic [ADDR_W-1:0] fa_addr;
        logic              fb_rd;
        logic [ADDR_W-1:0] fb_addr;
        logic              b_from_work;
        logic              w_rd;
        logic [IDX_W-1:0]  w_rd_addr;
        logic              m_rd;
        logic [ADDR_W-1:0] m_rd_addr;
        logic              r_rd;
        logic [IDX_W-1:0]  r_rd_addr;
        t_base             base_sel;
        logic              unit_start;
        logic              unit_sqrt;
        logic              den_from_root;
        logic              f_wr;
        logic [ADDR_W-1:0] f_wr_addr;
        logic              root_load;
        logic              w_wr;
        logic [IDX_W-1:0]  w_wr_addr;
        logic              ld_mat;
        logic              ld_rhs;
        logic              out_load;
        t_status           out_status;
        logic [IDX_W-1:0]  out_index;
        logic              out_last;
        logic              out_zero;
    } t_cmd;

    typedef struct packed {
        logic diff_nonpos;
        logic unit_busy;
        logic root_zero;
        logic out_free;
    } t_stat;

    // Clamp a widened value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W:0] v);
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        hi = (ACC_W+1)'(2147483647);
        lo = -hi - (ACC_W+1)'(1);
        if (v > hi) begin
            sat32 = hi[DATA_W-1:0];
        end else if (v < lo) begin
            sat32 = lo[DATA_W-1:0];
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

### src/cfs_ram.sv
// ============================================================================
// cfs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/cfs_unit.sv
// ============================================================================
// cfs_unit
// Iterative square root (two radicand bits per cycle) and rounded divider
// (one quotient bit per cycle), sharing one shift register.
// ============================================================================
module cfs_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_sqrt,
    input  logic signed [cfs_pkg::DATA_W-1:0] i_num,
    input  logic [cfs_pkg::DATA_W-1:0] i_den,
    output logic                      o_busy,
    output logic signed [cfs_pkg::DATA_W-1:0] o_result
);

    localparam int DW = cfs_pkg::DATA_W;
    localparam int VW = cfs_pkg::DIV_W;
    localparam int RW = VW / 2;

    logic                       r_busy;
    logic                       r_sqrt;
    logic                       r_sign;
    logic [cfs_pkg::CNT_W-1:0]  r_cnt;
    logic [VW-1:0]              r_dvd;
    logic [DW-1:0]              r_rem;
    logic [DW-1:0]              r_den;
    logic [RW-1:0]              r_root;

    logic [DW-1:0] w_mag;
    logic [DW-1:0] w_t;
    logic [DW-1:0] w_trial;
    logic          w_take;
    logic [VW-1:0] w_q;

    assign w_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);

    always_comb begin
        if (r_sqrt) begin
            w_t     = {r_rem[DW-3:0], r_dvd[VW-1 -: 2]};
            w_trial = {{(DW-RW-2){1'b0}}, r_root, 2'b01};
        end else begin
            w_t     = {r_rem[DW-2:0], r_dvd[VW-1]};
            w_trial = r_den;
        end
        w_take = (w_t >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == cfs_pkg::CNT_W'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sqrt <= i_sqrt;
            r_sign <= i_num[DW-1];
            r_rem  <= '0;
            r_root <= '0;
            r_den  <= i_den;
            if (i_sqrt) begin
                r_cnt <= cfs_pkg::CNT_W'(cfs_pkg::SQ_STEPS);
                r_dvd <= {1'b0, i_num[DW-2:0], {cfs_pkg::FRAC{1'b0}}};
            end else begin
                r_cnt <= cfs_pkg::CNT_W'(VW);
                r_dvd <= {w_mag, {cfs_pkg::FRAC{1'b0}}} + VW'(i_den >> 1);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - cfs_pkg::CNT_W'(1);
            r_rem <= w_take ? (w_t - w_trial) : w_t;
            if (r_sqrt) begin
                r_dvd  <= {r_dvd[VW-3:0], 2'b00};
                r_root <= {r_root[RW-2:0], w_take};
            end else begin
                r_dvd <= {r_dvd[VW-2:0], w_take};
            end
        end
    end

    // Saturate the quotient into the signed word; a root passes through unsigned
    assign w_q = r_dvd;
    always_comb begin
        if (r_sqrt) begin
            o_result = {{(DW-RW){1'b0}}, r_root};
        end else if (r_sign) begin
            if (w_q > VW'(64'h8000_0000)) begin
                o_result = {1'b1, {(DW-1){1'b0}}};
            end else begin
                o_result = DW'(-w_q);
            end
        end else if (w_q > VW'(64'h7FFF_FFFF)) begin
            o_result = {1'b0, {(DW-1){1'b1}}};
        end else begin
            o_result = w_q[DW-1:0];
        end
    end

    assign o_busy = r_busy;

endmodule

### src/cfs_dpath.sv
// ============================================================================
// cfs_dpath
// Stores, multiply-accumulate pipeline, difference, sqrt/divide unit and output register.
// ============================================================================
module cfs_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cfs_pkg::t_cmd                     i_cmd,
    output cfs_pkg::t_stat                    o_stat,
    input  logic [cfs_pkg::IDX_W-1:0]         i_row_index,
    input  logic [cfs_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [cfs_pkg::DATA_W-1:0] i_element_value,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [cfs_pkg::IDX_W-1:0]         o_result_index,
    output logic signed [cfs_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_last_of_run,
    output logic [1:0]                        o_status
);

    localparam int DW = cfs_pkg::DATA_W;
    localparam int AW = cfs_pkg::ACC_W;

    logic [DW-1:0] w_m_rd, w_fa_rd, w_fb_rd, w_r_rd, w_w_rd;
    logic [DW-1:0] w_unit_res;
    logic          w_unit_busy;

    logic                    r_v1, r_v2;
    logic signed [2*DW-1:0]  r_prod;
    logic signed [2*DW-1:0]  w_rnd;
    logic signed [AW-1:0]    r_acc;
    logic signed [DW-1:0]    w_b_op;
    logic signed [DW-1:0]    w_base;
    logic signed [AW:0]      w_diff;
    logic signed [DW-1:0]    w_diff_sat;
    logic [DW-1:0]           r_root_den;
    logic [DW-1:0]           w_den;

    logic                         r_out_valid;
    logic [cfs_pkg::IDX_W-1:0]    r_out_index;
    logic [DW-1:0]                r_out_value;
    logic                         r_out_last;
    cfs_pkg::t_status             r_out_status;

    cfs_ram #(.WIDTH(DW), .DEPTH(cfs_pkg::ORD * cfs_pkg::ORD)) u_mat (
        .i_clk, .i_we(i_cmd.ld_mat), .i_wr_addr({i_row_index, i_col_index}),
        .i_wr_data(i_element_value), .i_rd_en(i_cmd.m_rd), .i_rd_addr(i_cmd.m_rd_addr),
        .o_rd_data(w_m_rd));

    // Factor store kept twice so two entries can be read per cycle
    cfs_ram #(.WIDTH(DW), .DEPTH(cfs_pkg::ORD * cfs_pkg::ORD)) u_fac_a (
        .i_clk, .i_we(i_cmd.f_wr), .i_wr_addr(i_cmd.f_wr_addr), .i_wr_data(w_unit_res),
        .i_rd_en(i_cmd.fa_rd), .i_rd_addr(i_cmd.fa_addr), .o_rd_data(w_fa_rd));

    cfs_ram #(.WIDTH(DW), .DEPTH(cfs_pkg::ORD * cfs_pkg::ORD)) u_fac_b (
        .i_clk, .i_we(i_cmd.f_wr), .i_wr_addr(i_cmd.f_wr_addr), .i_wr_data(w_unit_res),
        .i_rd_en(i_cmd.fb_rd), .i_rd_addr(i_cmd.fb_addr), .o_rd_data(w_fb_rd));

    cfs_ram #(.WIDTH(DW), .DEPTH(cfs_pkg::ORD)) u_rhs (
        .i_clk, .i_we(i_cmd.ld_rhs), .i_wr_addr(i_row_index), .i_wr_data(i_element_value),
        .i_rd_en(i_cmd.r_rd), .i_rd_addr(i_cmd.r_rd_addr), .o_rd_data(w_r_rd));

    cfs_ram #(.WIDTH(DW), .DEPTH(cfs_pkg::ORD)) u_work (
        .i_clk, .i_we(i_cmd.w_wr), .i_wr_addr(i_cmd.w_wr_addr), .i_wr_data(w_unit_res),
        .i_rd_en(i_cmd.w_rd), .i_rd_addr(i_cmd.w_rd_addr), .o_rd_data(w_w_rd));

    // Multiply-accumulate: read, multiply, round and add
    assign w_b_op = i_cmd.b_from_work ? w_w_rd : w_fb_rd;
    assign w_rnd  = (r_prod + (2*DW)'(64'sd1 <<< (cfs_pkg::FRAC - 1))) >>> cfs_pkg::FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= $signed(w_fa_rd) * w_b_op;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + w_rnd[AW-1:0];
        end
        if (i_cmd.root_load) begin
            r_root_den <= w_unit_res;
        end
    end

    // Difference of base element and accumulated sum
    always_comb begin
        case (i_cmd.base_sel)
            cfs_pkg::BASE_MAT: w_base = w_m_rd;
            cfs_pkg::BASE_RHS: w_base = w_r_rd;
            default:           w_base = w_w_rd;
        endcase
    end

    assign w_diff     = (AW+1)'(w_base) - (AW+1)'(r_acc);
    assign w_diff_sat = cfs_pkg::sat32(w_diff);
    assign w_den      = i_cmd.den_from_root ? r_root_den : w_fa_rd;

    cfs_unit u_unit (
        .i_clk, .i_rst_n, .i_start(i_cmd.unit_start), .i_sqrt(i_cmd.unit_sqrt),
        .i_num(w_diff_sat), .i_den(w_den), .o_busy(w_unit_busy), .o_result(w_unit_res));

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index  <= i_cmd.out_index;
            r_out_value  <= i_cmd.out_zero ? '0 : w_w_rd;
            r_out_last   <= i_cmd.out_last;
            r_out_status <= i_cmd.out_status;
        end
    end

    assign o_stat.diff_nonpos = w_diff[AW] || (w_diff == '0);
    assign o_stat.unit_busy   = w_unit_busy;
    assign o_stat.root_zero   = (w_unit_res == '0);
    assign o_stat.out_free    = !r_out_valid || i_ready;

    assign o_valid        = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_result_value = r_out_value;
    assign o_last_of_run  = r_out_last;
    assign o_status       = r_out_status;

endmodule

### src/cfs_ctrl.sv
// ============================================================================
// cfs_ctrl
// Sequencer for factor and solve loops, order register and factor flag.
// ============================================================================
module cfs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_opcode,
    input  logic                       i_cfg_we,
    input  logic [cfs_pkg::SIZE_W-1:0] i_cfg_data,
    output cfs_pkg::t_cmd              o_cmd,
    input  cfs_pkg::t_stat             i_stat
);

    localparam int IW = cfs_pkg::IDX_W;

    cfs_pkg::t_state  r_state, n_state;
    cfs_pkg::t_phase  r_phase, n_phase;
    cfs_pkg::t_status r_st_code, n_st_code;
    logic [IW-1:0]    r_i, n_i, r_j, n_j, r_k, n_k;
    logic [cfs_pkg::SIZE_W-1:0] r_size, n_size;
    logic             r_fvalid, n_fvalid;
    logic [IW-1:0]    w_nm1;
    logic             w_diag;

    always_comb begin
        if (r_size == '0) begin
            w_nm1 = '0;
        end else if (r_size > cfs_pkg::SIZE_W'(cfs_pkg::ORD)) begin
            w_nm1 = IW'(cfs_pkg::ORD - 1);
        end else begin
            w_nm1 = IW'(r_size - cfs_pkg::SIZE_W'(1));
        end
    end

    assign w_diag = (r_phase == cfs_pkg::PH_FACT) && (r_i == r_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cfs_pkg::S_IDLE;
            r_phase   <= cfs_pkg::PH_FACT;
            r_st_code <= cfs_pkg::ST_OK;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_size    <= cfs_pkg::SIZE_W'(cfs_pkg::ORD);
            r_fvalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_st_code <= n_st_code;
            r_i       <= n_i;
            r_j       <= n_j;
            r_k       <= n_k;
            r_size    <= n_size;
            r_fvalid  <= n_fvalid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_st_code = r_st_code;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_size    = r_size;
        n_fvalid  = r_fvalid;
        o_ready   = 1'b0;
        o_cmd     = '0;

        o_cmd.base_sel      = (r_phase == cfs_pkg::PH_FACT) ? cfs_pkg::BASE_MAT :
                              (r_phase == cfs_pkg::PH_FWD)  ? cfs_pkg::BASE_RHS :
                                                              cfs_pkg::BASE_WORK;
        o_cmd.den_from_root = (r_phase == cfs_pkg::PH_FACT);
        o_cmd.unit_sqrt     = w_diag;
        o_cmd.b_from_work   = (r_phase != cfs_pkg::PH_FACT);
        o_cmd.out_status    = cfs_pkg::ST_OK;

        unique case (r_state)
            cfs_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (cfs_pkg::t_opcode'(i_opcode))
                        cfs_pkg::OP_LOAD_MAT: o_cmd.ld_mat = 1'b1;
                        cfs_pkg::OP_LOAD_RHS: o_cmd.ld_rhs = 1'b1;
                        cfs_pkg::OP_FACTOR: begin
                            n_phase = cfs_pkg::PH_FACT;
                            n_i     = '0;
                            n_j     = '0;
                            n_state = cfs_pkg::S_ENTRY;
                        end
                        cfs_pkg::OP_SOLVE: begin
                            if (r_fvalid) begin
                                n_phase = cfs_pkg::PH_FWD;
                                n_i     = '0;
                                n_state = cfs_pkg::S_ENTRY;
                            end else begin
                                n_st_code = cfs_pkg::ST_NO_FACTOR;
                                n_state   = cfs_pkg::S_STATUS;
                            end
                        end
                    endcase
                end
            end
            cfs_pkg::S_ENTRY: begin
                // clear the sum and skip the dot product when it is empty
                o_cmd.acc_clr = 1'b1;
                if (r_phase == cfs_pkg::PH_BWD) begin
                    n_k     = r_i + IW'(1);
                    n_state = (r_i == w_nm1) ? cfs_pkg::S_W1 : cfs_pkg::S_MAC;
                end else begin
                    n_k     = '0;
                    n_state = (r_i == '0) ? cfs_pkg::S_W1 : cfs_pkg::S_MAC;
                end
            end
            cfs_pkg::S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                o_cmd.fa_rd     = 1'b1;
                if (r_phase == cfs_pkg::PH_BWD) begin
                    o_cmd.fa_addr = {r_i, r_k};
                end else begin
                    o_cmd.fa_addr = {r_k, r_i};
                end
                if (r_phase == cfs_pkg::PH_FACT) begin
                    o_cmd.fb_rd   = 1'b1;
                    o_cmd.fb_addr = {r_k, r_j};
                end else begin
                    o_cmd.w_rd      = 1'b1;
                    o_cmd.w_rd_addr = r_k;
                end
                n_k = r_k + IW'(1);
                if ((r_phase == cfs_pkg::PH_BWD) ? (r_k == w_nm1) : (r_k == r_i - IW'(1))) begin
                    n_state = cfs_pkg::S_W1;
                end
            end
            cfs_pkg::S_W1: begin
                // fetch the base element and, when solving, the diagonal divisor
                unique case (r_phase)
                    cfs_pkg::PH_FACT: begin
                        o_cmd.m_rd      = 1'b1;
                        o_cmd.m_rd_addr = {r_i, r_j};
                    end
                    cfs_pkg::PH_FWD: begin
                        o_cmd.r_rd      = 1'b1;
                        o_cmd.r_rd_addr = r_i;
                        o_cmd.fa_rd     = 1'b1;
                        o_cmd.fa_addr   = {r_i, r_i};
                    end
                    default: begin
                        o_cmd.w_rd      = 1'b1;
                        o_cmd.w_rd_addr = r_i;
                        o_cmd.fa_rd     = 1'b1;
                        o_cmd.fa_addr   = {r_i, r_i};
                    end
                endcase
                n_state = cfs_pkg::S_W2;
            end
            cfs_pkg::S_W2: begin
                n_state = cfs_pkg::S_CALC;
            end
            cfs_pkg::S_CALC: begin
                if (w_diag && i_stat.diff_nonpos) begin
                    n_st_code = cfs_pkg::ST_NOT_PD;
                    n_fvalid  = 1'b0;
                    n_state   = cfs_pkg::S_STATUS;
                end else begin
                    o_cmd.unit_start = 1'b1;
                    n_state          = cfs_pkg::S_RUN;
                end
            end
            cfs_pkg::S_RUN: begin
                if (!i_stat.unit_busy) begin
                    n_state = cfs_pkg::S_ENTRY;
                    unique case (r_phase)
                        cfs_pkg::PH_FACT: begin
                            o_cmd.f_wr      = 1'b1;
                            o_cmd.f_wr_addr = {r_i, r_j};
                            o_cmd.root_load = w_diag;
                            if (w_diag && i_stat.root_zero) begin
                                n_st_code = cfs_pkg::ST_NOT_PD;
                                n_fvalid  = 1'b0;
                                n_state   = cfs_pkg::S_STATUS;
                            end else if (r_j != w_nm1) begin
                                n_j = r_j + IW'(1);
                            end else if (r_i != w_nm1) begin
                                n_i = r_i + IW'(1);
                                n_j = r_i + IW'(1);
                            end else begin
                                n_st_code = cfs_pkg::ST_OK;
                                n_fvalid  = 1'b1;
                                n_state   = cfs_pkg::S_STATUS;
                            end
                        end
                        cfs_pkg::PH_FWD: begin
                            o_cmd.w_wr      = 1'b1;
                            o_cmd.w_wr_addr = r_i;
                            if (r_i == w_nm1) begin
                                n_phase = cfs_pkg::PH_BWD;
                            end else begin
                                n_i = r_i + IW'(1);
                            end
                        end
                        default: begin
                            o_cmd.w_wr      = 1'b1;
                            o_cmd.w_wr_addr = r_i;
                            if (r_i == '0) begin
                                n_state = cfs_pkg::S_EMIT_RD;
                            end else begin
                                n_i = r_i - IW'(1);
                            end
                        end
                    endcase
                end
            end
            cfs_pkg::S_EMIT_RD: begin
                o_cmd.w_rd      = 1'b1;
                o_cmd.w_rd_addr = r_i;
                n_state         = cfs_pkg::S_EMIT;
            end
            cfs_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_index = r_i;
                    o_cmd.out_last  = (r_i == w_nm1);
                    if (r_i == w_nm1) begin
                        n_state = cfs_pkg::S_IDLE;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_state = cfs_pkg::S_EMIT_RD;
                    end
                end
            end
            cfs_pkg::S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_index  = '0;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_zero   = 1'b1;
                    o_cmd.out_status = r_st_code;
                    n_state          = cfs_pkg::S_IDLE;
                end
            end
            default: n_state = cfs_pkg::S_IDLE;
        endcase

        // a new order invalidates the factor
        if (i_cfg_we) begin
            n_size   = i_cfg_data;
            n_fvalid = 1'b0;
        end
    end

endmodule

### src/cholesky_factor_solve.sv
// ============================================================================
// cholesky_factor_solve
// Cholesky factor-and-solve engine for signed Q16.16 matrices up to 16x16.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_ready) carries one item per handshake: load a
//   matrix element, factor, load a right-hand-side element, or solve. Only
//   the diagonal and upper triangle of the matrix are used.
//   Loads give no result. Factor gives one status item.
//   Solve gives n solution items (index 0..n-1, last flag on the final one),
//   or a single "no factor" status item.
//   Output channel (o_valid / i_ready) is a register; the block returns to
//   idle and takes the next item while the final result still waits.
//   Config: i_cfg_we writes the order; write only while idle. It drops the
//   factor.
// Sequencing (n = order), one item at a time:
//   factor walks the n(n+1)/2 upper entries: a dot product, then a root on
//     the diagonal or a division off it.
//   solve walks 2n entries (forward, then back substitution), then emits.
//   Each entry waits on the bit-serial root/divide unit.
// Reset: synchronous, active low; clears the sequencer, the output valid,
//   the factor flag and sets the order to 16. Stores hold no reset value.
// Stall: a held output register stalls the sequencer at its next result.
// ============================================================================
module cholesky_factor_solve (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [cfs_pkg::IDX_W-1:0]         i_row_index,
    input  logic [cfs_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [cfs_pkg::DATA_W-1:0] i_element_value,
    input  logic                              i_cfg_we,
    input  logic [cfs_pkg::SIZE_W-1:0]        i_cfg_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cfs_pkg::IDX_W-1:0]         o_result_index,
    output logic signed [cfs_pkg::DATA_W-1:0] o_result_value,
    output logic                              o_last_of_run,
    output logic [1:0]                        o_status
);

    cfs_pkg::t_cmd  w_cmd;
    cfs_pkg::t_stat w_stat;

    // Sequencer: walks factor rows, forward and back substitution, emission
    cfs_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_opcode,
        .i_cfg_we, .i_cfg_data, .o_cmd(w_cmd), .i_stat(w_stat));

    // Datapath: stores, MAC pipeline, sqrt/divide unit, output register
    cfs_dpath u_dpath (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_row_index, .i_col_index, .i_element_value,
        .i_ready, .o_valid, .o_result_index, .o_result_value,
        .o_last_of_run, .o_status);

    // Divider/root unit is never busy while the block takes items
    a_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_stat.unit_busy)
        else $error("unit busy while idle");

    // Sequencer never overwrites an unconsumed result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output overrun");

    // A no-factor status is a lone result at index zero
    a_nofactor_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cfs_pkg::ST_NO_FACTOR) |-> (o_last_of_run && o_result_index == '0))
        else $error("bad no-factor result");

endmodule
